// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL; laguerre_polynomial_eval includes them.
// Under synthesis every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/lpe_pkg.sv =====
`timescale 1ns / 1ps

package lpe_pkg;

   // Default configuration of the evaluator.
   localparam int MAX_DEGREE_DEF       = 31;
   localparam int X_FRAC_BITS_DEF      = 16;
   localparam int RESULT_FRAC_BITS_DEF = 24;

   // Fixed field widths.
   localparam int X_W   = 24;
   localparam int DEG_W = 5;
   localparam int ORD_W = 5;
   localparam int VAL_W = 64;

   // Half of a value word, the limb that the shared multiplier takes per step plus one extension bit.
   localparam int LIMB_W = 32;

   // Quotient bits produced per divider cycle.
   localparam int DIV_DIGITS = 8;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // Input and result words.
   typedef struct packed {
      logic [X_W-1:0]   x_value;
      logic [DEG_W-1:0] degree;
      logic [ORD_W-1:0] order;
   } req_word_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] poly_value;
      logic                    saturated;
   } rsp_word_type;

   // Microcode fields.
   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_LOAD      = 3'd1,
      OP_INIT      = 3'd2,
      OP_DIV_START = 3'd3,
      OP_WRITEBACK = 3'd4,
      OP_COEF      = 3'd5,
      OP_EMIT      = 3'd6
   } seq_op_type;

   typedef enum logic [2:0] {
      MUL_NONE   = 3'd0,
      MUL_LM1_LO = 3'd1,
      MUL_LM1_HI = 3'd2,
      MUL_LM2_LO = 3'd3,
      MUL_LM2_HI = 3'd4
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD   = 3'd0,
      ACC_LOAD   = 3'd1,
      ACC_ADD_HI = 3'd2,
      ACC_SUB_LO = 3'd3,
      ACC_SUB_HI = 3'd4
   } acc_op_type;

   typedef enum logic [2:0] {
      JMP_NEVER       = 3'd0,
      JMP_ALWAYS      = 3'd1,
      JMP_NO_REQ      = 3'd2,
      JMP_DEGREE_ZERO = 3'd3,
      JMP_DIV_BUSY    = 3'd4,
      JMP_LAST_STEP   = 3'd5,
      JMP_RSP_FULL    = 3'd6
   } jump_cond_type;

   localparam int PC_W = 4;

   // Program addresses.
   localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
   localparam logic [PC_W-1:0] PC_INIT      = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV_GO    = 4'd2;
   localparam logic [PC_W-1:0] PC_DIV_WAIT  = 4'd3;
   localparam logic [PC_W-1:0] PC_WRITEBACK = 4'd4;
   localparam logic [PC_W-1:0] PC_COEF      = 4'd5;
   localparam logic [PC_W-1:0] PC_MUL_A     = 4'd6;
   localparam logic [PC_W-1:0] PC_MUL_B     = 4'd7;
   localparam logic [PC_W-1:0] PC_MUL_C     = 4'd8;
   localparam logic [PC_W-1:0] PC_MUL_D     = 4'd9;
   localparam logic [PC_W-1:0] PC_ACC_LAST  = 4'd10;
   localparam logic [PC_W-1:0] PC_EMIT      = 4'd11;

   typedef struct packed {
      seq_op_type    op;
      mul_sel_type   mul_sel;
      acc_op_type    acc_op;
      jump_cond_type cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Status the datapath reports back for conditional jumps.
   typedef struct packed {
      logic no_req;
      logic degree_zero;
      logic div_busy;
      logic last_step;
      logic rsp_full;
   } cond_flags_type;

   // Control store. Each multiply step's product is registered and used by the accumulator in the step that follows.
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NONE, mul_sel: MUL_NONE, acc_op: ACC_HOLD,
            cond: JMP_NEVER, target: PC_WAIT};
      unique case (pc)
         PC_WAIT: begin
            w.op     = OP_LOAD;
            w.cond   = JMP_NO_REQ;
            w.target = PC_WAIT;
         end
         PC_INIT: begin
            w.op     = OP_INIT;
            w.cond   = JMP_DEGREE_ZERO;
            w.target = PC_EMIT;
         end
         PC_DIV_GO: begin
            w.op = OP_DIV_START;
         end
         PC_DIV_WAIT: begin
            w.cond   = JMP_DIV_BUSY;
            w.target = PC_DIV_WAIT;
         end
         PC_WRITEBACK: begin
            w.op     = OP_WRITEBACK;
            w.cond   = JMP_LAST_STEP;
            w.target = PC_EMIT;
         end
         PC_COEF: begin
            w.op = OP_COEF;
         end
         PC_MUL_A: begin
            w.mul_sel = MUL_LM1_LO;
         end
         PC_MUL_B: begin
            w.mul_sel = MUL_LM1_HI;
            w.acc_op  = ACC_LOAD;
         end
         PC_MUL_C: begin
            w.mul_sel = MUL_LM2_LO;
            w.acc_op  = ACC_ADD_HI;
         end
         PC_MUL_D: begin
            w.mul_sel = MUL_LM2_HI;
            w.acc_op  = ACC_SUB_LO;
         end
         PC_ACC_LAST: begin
            w.acc_op = ACC_SUB_HI;
            w.cond   = JMP_ALWAYS;
            w.target = PC_DIV_GO;
         end
         PC_EMIT: begin
            w.op     = OP_EMIT;
            w.cond   = JMP_RSP_FULL;
            w.target = PC_EMIT;
         end
         default: begin
            w.cond   = JMP_ALWAYS;
            w.target = PC_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/laguerre_polynomial_eval.sv =====
// An accepted word of degree 0 goes from the init step straight to the emit step; other
// degrees run the step loop through the shared 33x25 multiplier and the 8-bit-per-cycle
// divider once per degree step. A new word is taken only after the result is loaded
// and the sequencer has returned to its wait step.
// Synchronous active-high reset returns the sequencer to its wait step and empties
// the result register; arithmetic registers are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module laguerre_polynomial_eval #(
   parameter int MAX_DEGREE       = lpe_pkg::MAX_DEGREE_DEF,
   parameter int X_FRAC_BITS      = lpe_pkg::X_FRAC_BITS_DEF,
   parameter int RESULT_FRAC_BITS = lpe_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lpe_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lpe_pkg::rsp_word_type rsp_word
);
   import lpe_pkg::*;

   ctrl_word_type  ctrl;
   cond_flags_type flags;

   // Program counter and control store.
   lpe_sequencer u_sequencer (
      .clock(clock),
      .reset(reset),
      .flags(flags),
      .ctrl (ctrl)
   );

   // Registers, multiplier, accumulator and divider.
   lpe_datapath #(
      .MAX_DEGREE      (MAX_DEGREE),
      .X_FRAC_BITS     (X_FRAC_BITS),
      .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .flags    (flags),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   // A new word is never accepted while a division is still running.
   `ASSERT_IMPLIES(a_accept_div_idle, clock, reset, req_valid && !req_stall, !flags.div_busy)
   // The divider is started only when it is idle.
   `ASSERT_IMPLIES(a_div_start_idle, clock, reset, ctrl.op == OP_DIV_START, !flags.div_busy)
   // An emit step with a free result register shows the word on the next cycle.
   `ASSERT_NEXT(a_emit_delivers, clock, reset, ctrl.op == OP_EMIT && !flags.rsp_full, rsp_valid)

endmodule

// ===== sv/lpe_divider.sv =====
`timescale 1ns / 1ps

module lpe_divider #(
   parameter int ACC_W       = 90,
   parameter int DIVN_W      = 5,
   parameter int X_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ACC_W-1:0]          numer,
   input  logic [DIVN_W-1:0]         divisor,
   output logic                      busy,
   output logic [lpe_pkg::VAL_W-1:0] quot_value,
   output logic                      quot_sat
);
   import lpe_pkg::*;

   localparam int N_W       = ACC_W - X_FRAC_BITS;
   localparam int DIV_STEPS = (N_W + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int PAD_W     = DIV_STEPS * DIV_DIGITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   logic [PAD_W-1:0]  num_ff, num_in;
   logic [DIVN_W-1:0] rem_ff, rem_in;
   logic [DIVN_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   logic [ACC_W-1:0]  half_w;
   logic [ACC_W-1:0]  mag_w;
   logic [DIVN_W:0]   part_w;
   logic [PAD_W-1:0]  shift_w;
   logic [DIVN_W-1:0] rem_w;
   logic              over_hi_w;

   // Rounded magnitude: |numer| plus half the full divisor, in one add or subtract.
   assign half_w = ACC_W'(divisor) << (X_FRAC_BITS - 1);
   assign mag_w  = numer[ACC_W-1] ? (half_w - numer) : (numer + half_w);

   // Restoring division by the step index, several quotient bits per cycle.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shift_w = num_ff;
      rem_w   = rem_ff;
      part_w  = '0;
      if (start) begin
         num_in  = PAD_W'(mag_w[ACC_W-1:X_FRAC_BITS]);
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = numer[ACC_W-1];
         cnt_in  = CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_DIGITS; i++) begin
            part_w  = {rem_w, shift_w[PAD_W-1]};
            shift_w = {shift_w[PAD_W-2:0], 1'b0};
            if (part_w >= {1'b0, den_ff}) begin
               part_w     = part_w - {1'b0, den_ff};
               shift_w[0] = 1'b1;
            end
            rem_w = part_w[DIVN_W-1:0];
         end
         num_in = shift_w;
         rem_in = rem_w;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and clip to the signed 64-bit range.
   assign over_hi_w = |num_ff[PAD_W-1:VAL_W];

   always_comb begin
      if (!neg_ff) begin
         quot_sat   = over_hi_w | num_ff[VAL_W-1];
         quot_value = quot_sat ? VAL_MAX : num_ff[VAL_W-1:0];
      end else begin
         quot_sat   = over_hi_w | (num_ff[VAL_W-1] & (|num_ff[VAL_W-2:0]));
         quot_value = quot_sat ? VAL_MIN : (~num_ff[VAL_W-1:0] + VAL_W'(1));
      end
   end

   assign busy = busy_ff;

endmodule

// ===== sv/lpe_datapath.sv =====
`timescale 1ns / 1ps

module lpe_datapath #(
   parameter int MAX_DEGREE       = lpe_pkg::MAX_DEGREE_DEF,
   parameter int X_FRAC_BITS      = lpe_pkg::X_FRAC_BITS_DEF,
   parameter int RESULT_FRAC_BITS = lpe_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpe_pkg::ctrl_word_type ctrl,
   output lpe_pkg::cond_flags_type flags,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lpe_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lpe_pkg::rsp_word_type  rsp_word
);
   import lpe_pkg::*;

   // Step index, coefficient, product and accumulator widths.
   localparam int DIVN_W  = $clog2(MAX_DEGREE + 1);
   localparam int K_W     = $clog2(2 * MAX_DEGREE + 31);
   localparam int KX_W    = K_W + X_FRAC_BITS;
   localparam int COEF_W  = ((KX_W > X_W) ? KX_W : X_W) + 1;
   localparam int PROD_W  = LIMB_W + 1 + COEF_W;
   localparam int ACC_W   = VAL_W + COEF_W + 1;
   localparam int EXT_W   = ACC_W - PROD_W;

   logic [X_W-1:0]    x_ff, x_in;
   logic [ORD_W-1:0]  q_ff, q_in;
   logic [DIVN_W-1:0] p_ff, p_in;
   logic [DIVN_W-1:0] n_ff, n_in;
   logic [VAL_W-1:0]  lm1_ff, lm1_in;
   logic [VAL_W-1:0]  lm2_ff, lm2_in;
   logic [COEF_W-1:0] c1_ff, c1_in;
   logic [COEF_W-1:0] c2_ff, c2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              sat_ff, sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic signed [LIMB_W:0]   mul_a;
   logic signed [COEF_W-1:0] mul_b;
   logic [ACC_W-1:0]  prod_ext;
   logic [ACC_W-1:0]  prod_hi;
   logic [K_W-1:0]    k1_w;
   logic [K_W-1:0]    k2_w;
   logic              accept_w;
   logic              rsp_full_w;
   logic              div_start_w;
   logic              div_busy_w;
   logic [VAL_W-1:0]  div_value_w;
   logic              div_sat_w;

   assign accept_w    = req_valid && (ctrl.op == OP_LOAD);
   assign rsp_full_w  = rsp_valid_ff && rsp_stall;
   assign div_start_w = (ctrl.op == OP_DIV_START);

   // Recurrence coefficients for step n: (2n+q-1) and (n+q-1).
   assign k1_w = K_W'({n_ff, 1'b0}) + K_W'(q_ff) - K_W'(1);
   assign k2_w = K_W'(n_ff) + K_W'(q_ff) - K_W'(1);

   // Shared multiplier: one 32-bit half of a value word times a coefficient.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      prod_in = prod_ff;
      case (ctrl.mul_sel)
         MUL_LM1_LO: begin
            mul_a   = $signed({1'b0, lm1_ff[LIMB_W-1:0]});
            mul_b   = $signed(c1_ff);
            prod_in = mul_a * mul_b;
         end
         MUL_LM1_HI: begin
            mul_a   = $signed({lm1_ff[VAL_W-1], lm1_ff[VAL_W-1:LIMB_W]});
            mul_b   = $signed(c1_ff);
            prod_in = mul_a * mul_b;
         end
         MUL_LM2_LO: begin
            mul_a   = $signed({1'b0, lm2_ff[LIMB_W-1:0]});
            mul_b   = $signed(c2_ff);
            prod_in = mul_a * mul_b;
         end
         MUL_LM2_HI: begin
            mul_a   = $signed({lm2_ff[VAL_W-1], lm2_ff[VAL_W-1:LIMB_W]});
            mul_b   = $signed(c2_ff);
            prod_in = mul_a * mul_b;
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   // The registered product, sign-extended and at both limb positions.
   assign prod_ext = {{EXT_W{prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_hi  = prod_ext << LIMB_W;

   // Accumulator and sequencer-driven register updates.
   always_comb begin
      x_in         = x_ff;
      q_in         = q_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      lm1_in       = lm1_ff;
      lm2_in       = lm2_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      sat_in       = sat_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (ctrl.acc_op)
         ACC_LOAD:   acc_in = prod_ext;
         ACC_ADD_HI: acc_in = acc_ff + prod_hi;
         ACC_SUB_LO: acc_in = acc_ff - prod_ext;
         ACC_SUB_HI: acc_in = acc_ff - prod_hi;
         default:    acc_in = acc_ff;
      endcase

      unique case (ctrl.op)
         OP_LOAD: begin
            if (req_valid) begin
               x_in = req_word.x_value;
               q_in = req_word.order;
               if (32'(req_word.degree) > MAX_DEGREE) begin
                  p_in = DIVN_W'(MAX_DEGREE);
               end else begin
                  p_in = DIVN_W'(req_word.degree);
               end
            end
         end
         OP_INIT: begin
            // Degree one numerator: (1+q) scaled to both formats, minus x scaled.
            acc_in = ((ACC_W'(q_ff) + ACC_W'(1)) << (RESULT_FRAC_BITS + X_FRAC_BITS))
                   - (ACC_W'(x_ff) << RESULT_FRAC_BITS);
            // Both history registers start at degree zero; the first writeback
            // then leaves L0 in lm2 and L1 in lm1.
            lm1_in = VAL_W'(1) << RESULT_FRAC_BITS;
            lm2_in = VAL_W'(1) << RESULT_FRAC_BITS;
            n_in   = DIVN_W'(1);
            sat_in = 1'b0;
         end
         OP_WRITEBACK: begin
            lm2_in = lm1_ff;
            lm1_in = div_value_w;
            sat_in = div_sat_w;
            n_in   = n_ff + DIVN_W'(1);
         end
         OP_COEF: begin
            c1_in = COEF_W'({k1_w, {X_FRAC_BITS{1'b0}}}) - COEF_W'(x_ff);
            c2_in = COEF_W'({k2_w, {X_FRAC_BITS{1'b0}}});
         end
         OP_EMIT: begin
            if (!rsp_full_w) begin
               rsp_word_in.poly_value = $signed((p_ff == '0) ? lm2_ff : lm1_ff);
               rsp_word_in.saturated  = sat_ff;
               rsp_valid_in           = 1'b1;
            end
         end
         default: begin
            sat_in = sat_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      q_ff        <= q_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      lm1_ff      <= lm1_in;
      lm2_ff      <= lm2_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Rounded division of the accumulated numerator by n scaled to the argument format.
   lpe_divider #(
      .ACC_W      (ACC_W),
      .DIVN_W     (DIVN_W),
      .X_FRAC_BITS(X_FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_w),
      .numer     (acc_ff),
      .divisor   (n_ff),
      .busy      (div_busy_w),
      .quot_value(div_value_w),
      .quot_sat  (div_sat_w)
   );

   // Status for the sequencer's jumps.
   always_comb begin
      flags.no_req      = !req_valid;
      flags.degree_zero = (p_ff == '0);
      flags.div_busy    = div_busy_w;
      flags.last_step   = div_sat_w || (n_ff >= p_ff);
      flags.rsp_full    = rsp_full_w;
   end

   assign req_stall = !(ctrl.op == OP_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== sv/lpe_sequencer.sv =====
`timescale 1ns / 1ps

module lpe_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  lpe_pkg::cond_flags_type flags,
   output lpe_pkg::ctrl_word_type  ctrl
);
   import lpe_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_word_type   word_w;
   logic            taken_w;

   // Fetch the control word of the current step.
   assign word_w = ucode_rom(pc_ff);

   // Evaluate the jump condition.
   always_comb begin
      case (word_w.cond)
         JMP_NEVER:       taken_w = 1'b0;
         JMP_ALWAYS:      taken_w = 1'b1;
         JMP_NO_REQ:      taken_w = flags.no_req;
         JMP_DEGREE_ZERO: taken_w = flags.degree_zero;
         JMP_DIV_BUSY:    taken_w = flags.div_busy;
         JMP_LAST_STEP:   taken_w = flags.last_step;
         JMP_RSP_FULL:    taken_w = flags.rsp_full;
         default:         taken_w = 1'b0;
      endcase
      pc_in = taken_w ? word_w.target : (pc_ff + PC_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = word_w;

endmodule
